[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define AST_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define AST_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed: next-cycle implication");

`endif

[src/lgs_pkg.sv]
`default_nettype none

package lgs_pkg;

    // Default grid edge; the stored grid is capped at the 8 x 8 the fields carry.
    localparam int GRID_SIZE_DEF = 8;
    localparam int FIELD_DIM     = 8;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_STEP = 2'd1,
        CMD_READ = 2'd2
    } cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } state_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[src/lgs_cell.sv]
`default_nettype none

// One row of the grid; loads directly or takes its neighbor's row on a shift.
module lgs_cell #(
    parameter int Width = lgs_pkg::FIELD_DIM
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lgs_pkg::cell_ctrl_t ctrl,
    input  wire logic [Width-1:0]    load_row,
    input  wire logic [Width-1:0]    shift_row,
    output logic      [Width-1:0]    row
);

    logic [Width-1:0] row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else if (ctrl.load)
        begin
            row_reg <= load_row;
        end
        else if (ctrl.shift)
        begin
            row_reg <= shift_row;
        end
    end

    assign row = row_reg;

endmodule

`default_nettype wire

[src/lgs_rule.sv]
`default_nettype none

// B3/S23 for one row from the rows above and below; out-of-grid cells are dead.
module lgs_rule #(
    parameter int Width = lgs_pkg::FIELD_DIM
) (
    input  wire logic [Width-1:0] above,
    input  wire logic [Width-1:0] cur,
    input  wire logic [Width-1:0] below,
    output logic      [Width-1:0] next_row
);

    // Pad one dead column on each side.
    logic [Width+1:0] a_pad;
    logic [Width+1:0] c_pad;
    logic [Width+1:0] b_pad;

    assign a_pad = {1'b0, above, 1'b0};
    assign c_pad = {1'b0, cur, 1'b0};
    assign b_pad = {1'b0, below, 1'b0};

    always_comb
    begin
        logic [3:0] n;
        for (int c = 0; c < Width; c++)
        begin
            n = 4'(a_pad[c]) + 4'(a_pad[c+1]) + 4'(a_pad[c+2])
              + 4'(c_pad[c])                  + 4'(c_pad[c+2])
              + 4'(b_pad[c]) + 4'(b_pad[c+1]) + 4'(b_pad[c+2]);
            next_row[c] = (n == 4'd3) || (cur[c] && (n == 4'd2));
        end
    end

endmodule

`default_nettype wire

[src/life_grid_generation_step.sv]
// Channel | Handshake            | Payload                                | Dir
// --------+----------------------+----------------------------------------+----
// request | cmd_valid/cmd_ready  | command, row_index, row_cells          | in
// result  | row_valid/row_ready  | out_row_index, out_row_cells, last_row | out
//
// Load: no result. Step and read: one row per cycle while the result is not
// stalled (grid edge rows, at most 8, per request) as the rows rotate once
// through the chain of row cells; the B3/S23 unit sits at the head of the chain.
// A stalled result holds the chain. Reset clears the grid at once, no sweep.
// A new request is taken only between step/read passes; the last row may still
// wait in the output register.
`default_nettype none

module life_grid_generation_step #(
    parameter int GRID_SIZE = lgs_pkg::GRID_SIZE_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    output logic            cmd_ready,
    input  wire logic [1:0] command,
    input  wire logic [2:0] row_index,
    input  wire logic [7:0] row_cells,
    output logic            row_valid,
    input  wire logic       row_ready,
    output logic [2:0]      out_row_index,
    output logic [7:0]      out_row_cells,
    output logic            last_row
);

    // Only an 8 x 8 corner fits the fields.
    localparam int GridDim = (GRID_SIZE > lgs_pkg::FIELD_DIM) ? lgs_pkg::FIELD_DIM
                                                                : GRID_SIZE;
    localparam int CntW    = $clog2(GridDim);

    lgs_pkg::state_t   state_reg, state_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic [GridDim-1:0] prev_reg, prev_next;    // old row above the head row
    logic              step_reg, step_next;     // 1: emit next generation

    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_idx_reg;
    logic [7:0]        out_cells_reg;
    logic              out_last_reg;

    logic              advance;
    logic              cnt_last;
    logic              load_fire;
    logic              shift_en;

    logic [GridDim-1:0] cell_row [GridDim];
    logic [GridDim-1:0] head_row;
    logic [GridDim-1:0] below_row;
    logic [GridDim-1:0] new_row;
    logic [GridDim-1:0] emit_row;

    assign cnt_last  = (cnt_reg == CntW'(GridDim - 1));
    assign head_row  = cell_row[0];
    // The cell behind the head already holds new row 0 on the last row.
    assign below_row = cnt_last ? '0 : cell_row[1];
    assign emit_row  = step_reg ? new_row : head_row;

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lgs_pkg::ST_IDLE;
            cnt_reg   <= '0;
            prev_reg  <= '0;
            step_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            prev_reg  <= prev_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        prev_next  = prev_reg;
        step_next  = step_reg;
        cmd_ready  = 1'b0;
        advance    = 1'b0;
        load_fire  = 1'b0;
        case (state_reg)
            lgs_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    case (command)
                        lgs_pkg::CMD_LOAD:
                        begin
                            load_fire = 1'b1;
                        end
                        lgs_pkg::CMD_STEP,
                        lgs_pkg::CMD_READ:
                        begin
                            state_next = lgs_pkg::ST_EMIT;
                            cnt_next   = '0;
                            prev_next  = '0;
                            step_next  = (command == lgs_pkg::CMD_STEP);
                        end
                        default:
                        begin
                            // unused command: taken and dropped
                        end
                    endcase
                end
            end
            lgs_pkg::ST_EMIT:
            begin
                // move one row whenever the output register is free or draining
                advance = !out_valid_reg || row_ready;
                if (advance)
                begin
                    prev_next = head_row;
                    cnt_next  = cnt_reg + CntW'(1);
                    if (cnt_last)
                    begin
                        state_next = lgs_pkg::ST_IDLE;
                        cnt_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = lgs_pkg::ST_IDLE;
            end
        endcase
    end

    assign shift_en = advance;

    // ---------------- chain of row cells ----------------
    for (genvar k = 0; k < GridDim; k++)
    begin : g_cell
        lgs_pkg::cell_ctrl_t ctrl;
        logic [GridDim-1:0]  shift_in;

        assign ctrl.load  = load_fire && (row_index == 3'(k));
        assign ctrl.shift = shift_en;

        if (k == GridDim - 1)
        begin : g_tail
            // new or unchanged row re-enters at the tail
            assign shift_in = emit_row;
        end
        else
        begin : g_body
            assign shift_in = cell_row[k+1];
        end

        lgs_cell #(
            .Width (GridDim)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .load_row  (row_cells[GridDim-1:0]),
            .shift_row (shift_in),
            .row       (cell_row[k])
        );
    end

    lgs_rule #(
        .Width (GridDim)
    ) u_rule (
        .above    (prev_reg),
        .cur      (head_row),
        .below    (below_row),
        .next_row (new_row)
    );

    // ---------------- output register ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (row_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_idx_reg   <= 3'(cnt_reg);
            out_cells_reg <= 8'(emit_row);
            out_last_reg  <= cnt_last;
        end
    end

    assign row_valid     = out_valid_reg;
    assign out_row_index = out_idx_reg;
    assign out_row_cells = out_cells_reg;
    assign last_row      = out_last_reg;

endmodule

`default_nettype wire

[src/lgs_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module lgs_checker #(
    parameter int GRID_SIZE = lgs_pkg::GRID_SIZE_DEF
) (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       cmd_valid,
    input wire logic       cmd_ready,
    input wire logic [1:0] command,
    input wire logic       row_valid,
    input wire logic       row_ready,
    input wire logic [2:0] out_row_index,
    input wire logic [7:0] out_row_cells,
    input wire logic       last_row
);

    localparam int GridDim = (GRID_SIZE > lgs_pkg::FIELD_DIM) ? lgs_pkg::FIELD_DIM
                                                                : GRID_SIZE;
    localparam logic [2:0] LastIdx = 3'(GridDim - 1);

    logic        emit_start;
    logic [11:0] res_bus;

    assign emit_start = cmd_valid && cmd_ready
                        && ((command == lgs_pkg::CMD_STEP) || (command == lgs_pkg::CMD_READ));
    assign res_bus = {out_row_index, out_row_cells, last_row};

    `AST_NXT(a_res_hold, clk, rst_n, row_valid && !row_ready, row_valid)
    `AST_NXT(a_res_stable, clk, rst_n, row_valid && !row_ready, $stable(res_bus))
    `AST_IMP(a_last_mark, clk, rst_n, row_valid, last_row == (out_row_index == LastIdx))
    `AST_NXT(a_busy_after_start, clk, rst_n, emit_start, !cmd_ready)

endmodule

bind life_grid_generation_step lgs_checker #(.GRID_SIZE(GRID_SIZE)) u_lgs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .command       (command),
    .row_valid     (row_valid),
    .row_ready     (row_ready),
    .out_row_index (out_row_index),
    .out_row_cells (out_row_cells),
    .last_row      (last_row)
);

`default_nettype wire
